@@ hdl/dap_pkg.sv @@
// Shared types and constants of the decimal amount parser.
// No dependencies; used by the top level and its checker.
package dap_pkg;

    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned AMOUNT_W   = 47;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned POS_W      = 6;
    localparam int unsigned MAX_DIG_W  = 4;
    localparam int unsigned OUT_DATA_W = 56;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [MAX_DIG_W-1:0] MAX_DIG_RESET   = 4'd12;
    localparam logic [COUNT_W-1:0]   FRACTION_DIGITS = 5'd2;
    localparam logic [COUNT_W-1:0]   COUNT_MAX       = 5'd31;
    localparam logic [POS_W-1:0]     POS_MAX         = 6'd63;
    localparam logic [AMOUNT_W-1:0]  VALUE_LIMIT     = 47'd99999999999999;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BAD      = 3'd2,
        ST_DECIMALS = 3'd3,
        ST_DIGITS   = 3'd4,
        ST_LONG     = 3'd5
    } status_t;

    // Packed result; first member sits in the highest bits.
    typedef struct packed {
        logic                has_point;
        logic [COUNT_W-1:0]  integer_digits;
        logic [AMOUNT_W-1:0] amount_value;
        status_t             status;
    } result_t;

endpackage

@@ hdl/decimal_amount_parser_top.sv @@
// Decimal amount parser: top level with parse state and a two-entry result buffer.
// Depends on dap_pkg.
//
// Usage:
//   s_axis carries the amount string, one character per item in tdata[7:0];
//   a zero byte ends the string. Every item is parsed in the cycle it is
//   accepted, so one item per cycle is sustained while s_axis_tready is high.
//   m_axis carries one result item per terminator; one accepted while the output
//   register is empty or draining sets m_axis_tvalid in the next cycle.
//   Non-terminator items give no result. Each step is one multiply-by-ten-and-add
//   on the 47-bit running value plus a compare against the value limit.
//   cfg_wr_en / cfg_wr_data write max_integer_digits (reset value 12); write
//   it only while no string is in progress.
//   Reset clears the parse state and the result buffer; the register returns
//   to 12.
//   When the receiver stalls, a result waits in the output register and a
//   second one can land in the skid register, so input keeps flowing until
//   both are full; s_axis_tready then drops until the output drains.
module decimal_amount_parser_top #(
    parameter int unsigned MAX_LEN = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [dap_pkg::MAX_DIG_W-1:0]  cfg_wr_data,
    // character stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [dap_pkg::CHAR_W-1:0]     s_axis_tdata,   // [7:0] char_byte
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [2:0] status, [49:3] amount_value, [54:50] integer_digits, [55] has_point
    output logic [dap_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam logic [dap_pkg::POS_W-1:0] LAST_POS = dap_pkg::POS_W'(MAX_LEN - 1);
    localparam int unsigned PROD_W = dap_pkg::AMOUNT_W + 4;

    // configuration register
    logic [dap_pkg::MAX_DIG_W-1:0] max_dig_reg;

    // parse state
    logic [dap_pkg::POS_W-1:0]    position_reg,   position_next;
    logic                         point_seen_reg, point_seen_next;
    logic [dap_pkg::COUNT_W-1:0]  frac_cnt_reg,   frac_cnt_next;
    logic [dap_pkg::COUNT_W-1:0]  whole_cnt_reg,  whole_cnt_next;
    dap_pkg::status_t             error_reg,      error_next;
    logic [dap_pkg::AMOUNT_W-1:0] acc_reg,        acc_next;

    // result buffer
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    dap_pkg::result_t out_data_reg, out_data_next;
    dap_pkg::result_t skid_data_reg, skid_data_next;

    logic             in_fire;
    logic             is_term;
    logic             is_point;
    logic             is_digit;
    logic [3:0]       digit;
    logic [PROD_W-1:0] prod;
    logic [dap_pkg::AMOUNT_W-1:0] acc_step;
    logic             push;
    logic             pop;
    dap_pkg::result_t result;
    dap_pkg::status_t status_sel;

    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign is_term  = (s_axis_tdata == dap_pkg::CHAR_NUL);
    assign is_point = (s_axis_tdata == dap_pkg::CHAR_POINT) && !point_seen_reg
                      && (position_reg != '0);
    assign is_digit = (s_axis_tdata >= dap_pkg::CHAR_ZERO)
                      && (s_axis_tdata <= dap_pkg::CHAR_NINE);
    assign digit    = s_axis_tdata[3:0];

    // acc * 10 + digit as two shifted copies and the digit, summed with two adds
    assign prod = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0} + PROD_W'(digit);
    assign acc_step = (prod > PROD_W'(dap_pkg::VALUE_LIMIT))
                      ? (dap_pkg::VALUE_LIMIT + dap_pkg::AMOUNT_W'(1))
                      : prod[dap_pkg::AMOUNT_W-1:0];

    // status at the terminator, highest precedence first
    always_comb
    begin
        priority if (error_reg != dap_pkg::ST_OK)
            status_sel = error_reg;
        else if (position_reg == '0)
            status_sel = dap_pkg::ST_EMPTY;
        else if (point_seen_reg && (frac_cnt_reg != dap_pkg::FRACTION_DIGITS))
            status_sel = dap_pkg::ST_DECIMALS;
        else if (whole_cnt_reg > {1'b0, max_dig_reg})
            status_sel = dap_pkg::ST_DIGITS;
        else if (acc_reg > dap_pkg::VALUE_LIMIT)
            status_sel = dap_pkg::ST_DIGITS;
        else
            status_sel = dap_pkg::ST_OK;
    end

    always_comb
    begin
        result.status         = status_sel;
        result.amount_value   = (status_sel == dap_pkg::ST_OK) ? acc_reg : '0;
        result.integer_digits = whole_cnt_reg;
        result.has_point      = point_seen_reg;
    end

    // parse state update
    always_comb
    begin
        position_next   = position_reg;
        point_seen_next = point_seen_reg;
        frac_cnt_next   = frac_cnt_reg;
        whole_cnt_next  = whole_cnt_reg;
        error_next      = error_reg;
        acc_next        = acc_reg;
        if (in_fire)
        begin
            priority if (is_term)
            begin
                // start over for the next string
                position_next   = '0;
                point_seen_next = 1'b0;
                frac_cnt_next   = '0;
                whole_cnt_next  = '0;
                error_next      = dap_pkg::ST_OK;
                acc_next        = '0;
            end
            else if (error_reg != dap_pkg::ST_OK)
            begin
                // drop everything up to the terminator
            end
            else if (!is_point && !is_digit)
                error_next = dap_pkg::ST_BAD;
            else if (position_reg >= LAST_POS)
                error_next = dap_pkg::ST_LONG;
            else
            begin
                if (is_point)
                    point_seen_next = 1'b1;
                else
                begin
                    acc_next = acc_step;
                    if (point_seen_reg)
                        frac_cnt_next = (frac_cnt_reg == dap_pkg::COUNT_MAX)
                                        ? frac_cnt_reg : frac_cnt_reg + 1'b1;
                    else
                        whole_cnt_next = (whole_cnt_reg == dap_pkg::COUNT_MAX)
                                         ? whole_cnt_reg : whole_cnt_reg + 1'b1;
                end
                position_next = (position_reg == dap_pkg::POS_MAX)
                                ? position_reg : position_reg + 1'b1;
            end
        end
    end

    // result buffer: output register backed by one skid entry
    assign push = in_fire && is_term;
    assign pop  = out_valid_reg && m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                // advance the waiting result
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = result;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = result;
            end
        end
        else if (push)
        begin
            // hold the new result behind the stalled one
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dig_reg    <= dap_pkg::MAX_DIG_RESET;
            position_reg   <= '0;
            point_seen_reg <= 1'b0;
            frac_cnt_reg   <= '0;
            whole_cnt_reg  <= '0;
            error_reg      <= dap_pkg::ST_OK;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                max_dig_reg <= cfg_wr_data;
            position_reg   <= position_next;
            point_seen_reg <= point_seen_next;
            frac_cnt_reg   <= frac_cnt_next;
            whole_cnt_reg  <= whole_cnt_next;
            error_reg      <= error_next;
            acc_reg        <= acc_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ hdl/dap_checker.sv @@
// Port-level checks for the decimal amount parser, bound to the top level.
// Depends on dap_pkg and decimal_amount_parser_top.
module dap_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [dap_pkg::CHAR_W-1:0]     s_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [dap_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a failing status carries a zero amount
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] != dap_pkg::ST_OK) |-> m_axis_tdata[49:3] == '0)
        else $error("nonzero amount with error status");

    // an ok amount stays within the value limit
    a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == dap_pkg::ST_OK)
        |-> m_axis_tdata[49:3] <= dap_pkg::VALUE_LIMIT)
        else $error("ok amount above limit");

    // a terminator accepted into an idle output shows up in the next cycle
    a_term_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata == dap_pkg::CHAR_NUL)
        && !m_axis_tvalid |=> m_axis_tvalid)
        else $error("terminator produced no result");

endmodule

bind decimal_amount_parser_top dap_checker u_dap_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
